// ----- sv/lts_pkg.sv -----
// Shared types and constants of the Lox token scanner.
`default_nettype none
package lts_pkg;

    localparam logic [5:0] K_DOT    = 6'd5;
    localparam logic [5:0] K_SLASH  = 6'd9;
    localparam logic [5:0] K_BANG   = 6'd11;
    localparam logic [5:0] K_EQUAL  = 6'd13;
    localparam logic [5:0] K_GREATER = 6'd15;
    localparam logic [5:0] K_LESS   = 6'd17;
    localparam logic [5:0] K_IDENT  = 6'd19;
    localparam logic [5:0] K_STRING = 6'd20;
    localparam logic [5:0] K_NUMBER = 6'd21;
    localparam logic [5:0] K_KEY0   = 6'd22;
    localparam logic [5:0] K_END    = 6'd37;
    localparam logic [5:0] K_BAD    = 6'd38;

    localparam int NUM_KEYWORDS = 15;
    localparam int MAX_RESULTS  = 3;

    // Register index of first_line.
    localparam logic REG_FIRST_LINE = 1'b0;

    // Keywords packed with the first character in the lowest byte.
    localparam logic [63:0] KW_WORD [NUM_KEYWORDS] = '{
        64'h646e61, 64'h7373616c63, 64'h65736c65, 64'h65736c6166, 64'h726f66,
        64'h6e7566, 64'h6669, 64'h726f, 64'h746e697270, 64'h6e7275746572,
        64'h7265707573, 64'h73696874, 64'h65757274, 64'h726176, 64'h656c696877
    };

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic        unterm;
    } t_res;

    typedef struct packed {
        logic [1:0]      cnt;
        t_res [2:0]      res;
    } t_bundle;

    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(":     k = 6'd0;
            ")":     k = 6'd1;
            "{":     k = 6'd2;
            "}":     k = 6'd3;
            ",":     k = 6'd4;
            ".":     k = K_DOT;
            "-":     k = 6'd6;
            "+":     k = 6'd7;
            ";":     k = 6'd8;
            "*":     k = 6'd10;
            default: k = 6'h3f;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] p);
        logic [5:0] k;
        case (p)
            "!":     k = K_BANG;
            "=":     k = K_EQUAL;
            ">":     k = K_GREATER;
            "<":     k = K_LESS;
            default: k = K_SLASH;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic [31:0] line_inc(input logic [31:0] l);
        return (l == 32'hFFFF_FFFF) ? l : l + 32'd1;
    endfunction

endpackage
`default_nettype wire

// ----- sv/lts_in_if.sv -----
// Source byte channel of the token scanner.
`default_nettype none
interface lts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;
    logic       byte_valid;
    logic       end_of_source;

    modport source (output valid, src_byte, byte_valid, end_of_source, input ready);
    modport sink (input valid, src_byte, byte_valid, end_of_source, output ready);
endinterface
`default_nettype wire

// ----- sv/lts_out_if.sv -----
// Token channel of the token scanner.
`default_nettype none
interface lts_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] lexeme_length;
    logic [31:0] line_number;
    logic        unterminated;
    logic        last_result;

    modport source (output valid, token_kind, start_offset, lexeme_length, line_number,
                    unterminated, last_result, input ready);
    modport sink (input valid, token_kind, start_offset, lexeme_length, line_number,
                  unterminated, last_result, output ready);
endinterface
`default_nettype wire

// ----- sv/lts_core.sv -----
// Scanner state registers and the per-byte next-state and token logic.
`default_nettype none
module lts_core
    import lts_pkg::*;
#(
    parameter int OFFSET_BITS     = 32,
    parameter int MAX_KEYWORD_LEN = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_src_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_end_of_source,
    input  wire logic        i_cfg_load,
    input  wire logic [15:0] i_cfg_line,
    input  wire logic [15:0] i_first_line,
    output t_bundle          o_bundle
);

    localparam int WB = 8 * MAX_KEYWORD_LEN;
    localparam int WL = $clog2(MAX_KEYWORD_LEN + 2);
    localparam int OB = OFFSET_BITS;

    typedef enum logic [2:0] {
        M_IDLE, M_OP, M_COMMENT, M_STRING, M_INT, M_DOT, M_FRAC, M_WORD
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [OB-1:0]  r_ts, n_ts, r_bpos, n_bpos;
    logic [31:0]    r_line, n_line;
    logic [WB-1:0]  r_wb, n_wb;
    logic [WL-1:0]  r_wl, n_wl;
    logic [7:0]     r_pend, n_pend;

    function automatic logic [5:0] word_kind(input logic [WB-1:0] wb, input logic [WL-1:0] wl);
        logic [5:0] k;
        k = K_IDENT;
        if (wl <= WL'(MAX_KEYWORD_LEN)) begin
            for (int i = 0; i < NUM_KEYWORDS; i++) begin
                if (wb == KW_WORD[i][WB-1:0]) begin
                    k = K_KEY0 + 6'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic t_res mk(input logic [5:0] kind, input logic [OB-1:0] start,
                                input logic [OB:0] len, input logic [31:0] line,
                                input logic unterm);
        t_res r;
        r.kind   = kind;
        r.start  = 32'(start);
        r.len    = 32'(len);
        r.line   = line;
        r.unterm = unterm;
        return r;
    endfunction

    always_comb begin
        logic [7:0]    c;
        logic [OB-1:0] pos;
        logic [OB-1:0] dp;
        logic [1:0]    cnt;
        logic          dflt;
        logic [5:0]    pk;
        t_res [2:0]    res;

        c      = i_src_byte;
        pos    = r_bpos;
        cnt    = 2'd0;
        dflt   = 1'b0;
        res    = '0;
        dp     = '0;
        n_mode = r_mode;
        n_ts   = r_ts;
        n_bpos = r_bpos;
        n_line = r_line;
        n_wb   = r_wb;
        n_wl   = r_wl;
        n_pend = r_pend;
        pk     = punct_kind(c);

        if (i_byte_valid) begin
            case (r_mode)
                M_OP: begin
                    if (c == "=" && r_pend != "/") begin
                        res[cnt] = mk(op_kind(r_pend) + 6'd1, r_ts, (OB+1)'(2), r_line, 1'b0);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == "/" && r_pend == "/") begin
                        n_mode = M_COMMENT;
                    end else begin
                        res[cnt] = mk(op_kind(r_pend), r_ts, (OB+1)'(1), r_line, 1'b0);
                        cnt = cnt + 2'd1;
                        dflt = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == "\n") begin
                        n_line = line_inc(r_line);
                        n_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    if (c == "\"") begin
                        res[cnt] = mk(K_STRING, r_ts, {1'b0, pos} - {1'b0, r_ts} + 1'b1,
                                      r_line, 1'b0);
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == "\n") begin
                        n_line = line_inc(r_line);
                    end
                end
                M_INT: begin
                    if (c == ".") begin
                        n_mode = M_DOT;
                    end else if (!is_digit(c)) begin
                        res[cnt] = mk(K_NUMBER, r_ts, {1'b0, pos} - {1'b0, r_ts}, r_line, 1'b0);
                        cnt = cnt + 2'd1;
                        dflt = 1'b1;
                    end
                end
                M_DOT, M_FRAC: begin
                    if (is_digit(c)) begin
                        n_mode = M_FRAC;
                    end else begin
                        res[cnt] = mk(K_NUMBER, r_ts, {1'b0, pos} - {1'b0, r_ts}, r_line, 1'b0);
                        cnt = cnt + 2'd1;
                        dflt = 1'b1;
                    end
                end
                M_WORD: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (r_wl < WL'(MAX_KEYWORD_LEN)) begin
                            n_wb[8*r_wl +: 8] = c;
                        end
                        if (r_wl <= WL'(MAX_KEYWORD_LEN)) begin
                            n_wl = r_wl + 1'b1;
                        end
                    end else begin
                        res[cnt] = mk(word_kind(r_wb, r_wl), r_ts, {1'b0, pos} - {1'b0, r_ts},
                                      r_line, 1'b0);
                        cnt = cnt + 2'd1;
                        dflt = 1'b1;
                    end
                end
                default: begin
                    dflt = 1'b1;
                end
            endcase

            if (dflt) begin
                n_mode = M_IDLE;
                n_ts   = pos;
                if (pk != 6'h3f) begin
                    res[cnt] = mk(pk, pos, (OB+1)'(1), r_line, 1'b0);
                    cnt = cnt + 2'd1;
                end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
                    n_pend = c;
                    n_mode = M_OP;
                end else if (c == " " || c == "\r" || c == "\t") begin
                    n_mode = M_IDLE;
                end else if (c == "\n") begin
                    n_line = line_inc(r_line);
                end else if (c == "\"") begin
                    n_mode = M_STRING;
                end else if (is_digit(c)) begin
                    n_mode = M_INT;
                end else if (is_alpha(c)) begin
                    n_wb = WB'(c);
                    n_wl = WL'(1);
                    n_mode = M_WORD;
                end else begin
                    res[cnt] = mk(K_BAD, pos, (OB+1)'(1), r_line, 1'b0);
                    cnt = cnt + 2'd1;
                end
            end

            if (pos != '1) begin
                n_bpos = pos + 1'b1;
            end
        end

        if (i_end_of_source) begin
            dp = (n_bpos > n_ts) ? n_bpos - 1'b1 : n_bpos;
            case (n_mode)
                M_OP: begin
                    res[cnt] = mk(op_kind(n_pend), n_ts, (OB+1)'(1), n_line, 1'b0);
                    cnt = cnt + 2'd1;
                end
                M_STRING: begin
                    res[cnt] = mk(K_STRING, n_ts, {1'b0, n_bpos} - {1'b0, n_ts}, n_line, 1'b1);
                    cnt = cnt + 2'd1;
                end
                M_INT, M_FRAC: begin
                    res[cnt] = mk(K_NUMBER, n_ts, {1'b0, n_bpos} - {1'b0, n_ts}, n_line, 1'b0);
                    cnt = cnt + 2'd1;
                end
                M_DOT: begin
                    res[cnt] = mk(K_NUMBER, n_ts, {1'b0, dp} - {1'b0, n_ts}, n_line, 1'b0);
                    cnt = cnt + 2'd1;
                    res[cnt] = mk(K_DOT, dp, (OB+1)'(1), n_line, 1'b0);
                    cnt = cnt + 2'd1;
                end
                M_WORD: begin
                    res[cnt] = mk(word_kind(n_wb, n_wl), n_ts, {1'b0, n_bpos} - {1'b0, n_ts},
                                  n_line, 1'b0);
                    cnt = cnt + 2'd1;
                end
                default: begin
                    cnt = cnt;
                end
            endcase
            res[cnt] = mk(K_END, n_bpos, '0, n_line, 1'b0);
            cnt = cnt + 2'd1;

            n_mode = M_IDLE;
            n_ts   = '0;
            n_bpos = '0;
            n_line = 32'(i_first_line);
            n_wb   = '0;
            n_wl   = '0;
            n_pend = '0;
        end

        o_bundle.cnt = cnt;
        o_bundle.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_ts   <= '0;
            r_bpos <= '0;
            r_line <= 32'd1;
            r_wb   <= '0;
            r_wl   <= '0;
            r_pend <= '0;
        end else if (i_cfg_load) begin
            r_line <= 32'(i_cfg_line);
        end else if (i_take) begin
            r_mode <= n_mode;
            r_ts   <= n_ts;
            r_bpos <= n_bpos;
            r_line <= n_line;
            r_wb   <= n_wb;
            r_wl   <= n_wl;
            r_pend <= n_pend;
        end
    end

endmodule
`default_nettype wire

// ----- sv/lts_out_buf.sv -----
// Result register that hands out the tokens of one byte, one word per cycle while the receiver is ready.
`default_nettype none
module lts_out_buf
    import lts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  t_bundle    i_bundle,
    output logic       o_can_take,
    lts_out_if.source  o_out
);

    t_bundle    r_buf;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_last;
    logic       w_pop;

    assign w_last     = (r_idx == r_buf.cnt - 2'd1);
    assign w_pop      = r_busy && o_out.ready;
    assign o_can_take = !r_busy || (w_pop && w_last);

    assign o_out.valid         = r_busy;
    assign o_out.token_kind    = r_buf.res[r_idx].kind;
    assign o_out.start_offset  = r_buf.res[r_idx].start;
    assign o_out.lexeme_length = r_buf.res[r_idx].len;
    assign o_out.line_number   = r_buf.res[r_idx].line;
    assign o_out.unterminated  = r_buf.res[r_idx].unterm;
    assign o_out.last_result   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= (i_bundle.cnt != 2'd0);
            r_idx  <= '0;
        end else if (w_pop) begin
            r_idx <= r_idx + 2'd1;
            if (w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_bundle;
        end
    end

endmodule
`default_nettype wire

// ----- sv/lox_token_scanner.sv -----
// Top level of the streaming Lox token scanner.
// The scanner takes one source byte per cycle and updates its state in the same cycle;
// the tokens a byte causes are held in one result register and handed out one word per
// cycle while the receiver is ready, so a byte that causes more than one token (at most three,
// end of source included) keeps the input waiting until the last of them drains. Writing
// first_line over the APB port at byte addresses 0 to 3 also loads the current line count.
`default_nettype none
module lox_token_scanner
    import lts_pkg::*;
#(
    parameter int OFFSET_BITS     = 32,
    parameter int MAX_KEYWORD_LEN = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    lts_in_if.sink           i_in,
    lts_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] r_first_line;
    logic        w_cfg_load;
    logic        w_can_take;
    logic        w_take;
    t_bundle     w_bundle;

    assign pready     = 1'b1;
    assign w_cfg_load = psel && penable && pwrite && (paddr[2] == REG_FIRST_LINE);
    assign prdata     = (paddr[2] == REG_FIRST_LINE) ? {16'd0, r_first_line} : 32'd0;
    assign i_in.ready = w_can_take;
    assign w_take     = i_in.valid && w_can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line <= 16'd1;
        end else if (w_cfg_load) begin
            r_first_line <= pwdata[15:0];
        end
    end

    lts_core #(
        .OFFSET_BITS     (OFFSET_BITS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (w_take),
        .i_src_byte      (i_in.src_byte),
        .i_byte_valid    (i_in.byte_valid),
        .i_end_of_source (i_in.end_of_source),
        .i_cfg_load      (w_cfg_load),
        .i_cfg_line      (pwdata[15:0]),
        .i_first_line    (r_first_line),
        .o_bundle        (w_bundle)
    );

    lts_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_take),
        .i_bundle   (w_bundle),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench of the Lox token scanner: directed sources, random sources and register settings.
`default_nettype none
module tb_top;
    import lts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] line;
        logic        unterm;
        logic        last;
    } t_token;

    typedef enum logic [2:0] {
        SC_IDLE, SC_OP, SC_COMMENT, SC_STRING, SC_INT, SC_DOT, SC_FRAC, SC_WORD
    } t_scan;

    localparam int WATCHDOG = 20000;
    localparam int MAX_KW   = 6;
    localparam logic [32:0] POS_MAX = 33'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    lts_in_if  in_ch();
    lts_out_if out_ch();

    lox_token_scanner u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    logic [15:0] first_line_q;
    t_scan       mode_q;
    logic [32:0] tok_start_q;
    logic [32:0] pos_q;
    logic [31:0] line_q;
    logic [63:0] word_q;
    int          word_len_q;
    logic [7:0]  pend_op_q;

    t_token expected_tokens[$];
    t_token batch[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.src_byte = '0;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_source = 1'b0;
        out_ch.ready = 1'b0;
    end

    function automatic logic [5:0] op_kind_of(logic [7:0] p);
        case (p)
            "!": return K_BANG;
            "=": return K_EQUAL;
            ">": return K_GREATER;
            "<": return K_LESS;
            default: return K_SLASH;
        endcase
    endfunction

    function automatic int punct_of(logic [7:0] c);
        case (c)
            "(": return 0; ")": return 1; "{": return 2; "}": return 3;
            ",": return 4; ".": return K_DOT; "-": return 6; "+": return 7;
            ";": return 8; "*": return 10;
            default: return -1;
        endcase
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void push_token(logic [5:0] k, logic [32:0] s, logic [32:0] l,
                                       logic u);
        t_token t;
        t.kind = k; t.start = s[31:0]; t.len = l[31:0]; t.line = line_q;
        t.unterm = u; t.last = 1'b0;
        batch.push_back(t);
    endfunction

    function automatic void bump_line();
        if (line_q != 32'hFFFF_FFFF) line_q++;
    endfunction

    function automatic logic [5:0] word_token_kind();
        if (word_len_q > MAX_KW) return K_IDENT;
        for (int i = 0; i < NUM_KEYWORDS; i++)
            if (KW_WORD[i] == word_q) return K_KEY0 + 6'(i);
        return K_IDENT;
    endfunction

    function automatic void add_char(logic [7:0] c);
        if (word_len_q < MAX_KW) word_q |= 64'(c) << (8 * word_len_q);
        if (word_len_q <= MAX_KW) word_len_q++;
    endfunction

    function automatic void restart_scan();
        mode_q = SC_IDLE; tok_start_q = '0; pos_q = '0; line_q = 32'(first_line_q);
        word_q = '0; word_len_q = 0; pend_op_q = '0;
    endfunction

    function automatic void scan_byte(logic [7:0] c, logic [32:0] p);
        int pk;
        case (mode_q)
            SC_OP: begin
                if (c == "=" && pend_op_q != "/") begin
                    push_token(op_kind_of(pend_op_q) + 6'd1, tok_start_q, 2, 0);
                    mode_q = SC_IDLE;
                    return;
                end
                if (c == "/" && pend_op_q == "/") begin
                    mode_q = SC_COMMENT;
                    return;
                end
                push_token(op_kind_of(pend_op_q), tok_start_q, 1, 0);
            end
            SC_COMMENT: begin
                if (c == "\n") begin
                    bump_line();
                    mode_q = SC_IDLE;
                end
                return;
            end
            SC_STRING: begin
                if (c == "\"") begin
                    push_token(K_STRING, tok_start_q, p + 1 - tok_start_q, 0);
                    mode_q = SC_IDLE;
                end else if (c == "\n") begin
                    bump_line();
                end
                return;
            end
            SC_INT: begin
                if (digit(c)) return;
                if (c == ".") begin
                    mode_q = SC_DOT;
                    return;
                end
                push_token(K_NUMBER, tok_start_q, p - tok_start_q, 0);
            end
            SC_DOT, SC_FRAC: begin
                if (digit(c)) begin
                    mode_q = SC_FRAC;
                    return;
                end
                push_token(K_NUMBER, tok_start_q, p - tok_start_q, 0);
            end
            SC_WORD: begin
                if (alpha(c) || digit(c)) begin
                    add_char(c);
                    return;
                end
                push_token(word_token_kind(), tok_start_q, p - tok_start_q, 0);
            end
            default: ;
        endcase
        mode_q = SC_IDLE;
        tok_start_q = p;
        pk = punct_of(c);
        if (pk >= 0) begin
            push_token(6'(pk), p, 1, 0);
        end else if (c == "!" || c == "=" || c == "<" || c == ">" || c == "/") begin
            pend_op_q = c;
            mode_q = SC_OP;
        end else if (c == " " || c == "\r" || c == "\t") begin
        end else if (c == "\n") begin
            bump_line();
        end else if (c == "\"") begin
            mode_q = SC_STRING;
        end else if (digit(c)) begin
            mode_q = SC_INT;
        end else if (alpha(c)) begin
            word_q = '0;
            word_len_q = 0;
            add_char(c);
            mode_q = SC_WORD;
        end else begin
            push_token(K_BAD, p, 1, 0);
        end
    endfunction

    function automatic void flush_source();
        logic [32:0] dp;
        case (mode_q)
            SC_OP: push_token(op_kind_of(pend_op_q), tok_start_q, 1, 0);
            SC_STRING: push_token(K_STRING, tok_start_q, pos_q - tok_start_q, 1);
            SC_INT, SC_FRAC: push_token(K_NUMBER, tok_start_q, pos_q - tok_start_q, 0);
            SC_DOT: begin
                dp = (pos_q > tok_start_q) ? pos_q - 1 : pos_q;
                push_token(K_NUMBER, tok_start_q, dp - tok_start_q, 0);
                push_token(K_DOT, dp, 1, 0);
            end
            SC_WORD: push_token(word_token_kind(), tok_start_q, pos_q - tok_start_q, 0);
            default: ;
        endcase
        push_token(K_END, pos_q, 0, 0);
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic bv, logic eos);
        logic [32:0] p;
        batch.delete();
        if (bv) begin
            p = pos_q;
            scan_byte(c, p);
            if (p < POS_MAX) pos_q = p + 1;
        end
        if (eos) begin
            flush_source();
            restart_scan();
        end
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_tokens.push_back(batch[i]);
    endfunction

    task automatic send_word(logic [7:0] c, logic bv, logic eos);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.src_byte <= c;
        in_ch.byte_valid <= bv;
        in_ch.end_of_source <= eos;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_tokens(c, bv, eos);
        @(negedge i_clk);
    endtask

    task automatic send_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, close && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_tokens.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_first_line(logic [15:0] v);
        wait_drained();
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(REG_FIRST_LINE) << 2; pwdata <= 32'(v);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        first_line_q = v;
        line_q = 32'(v);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            out_ch.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_token e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token kind %0d", out_ch.token_kind);
                errors++;
            end else begin
                e = expected_tokens.pop_front();
                if (out_ch.token_kind !== e.kind) begin
                    $error("token_kind expected %0d actual %0d", e.kind, out_ch.token_kind);
                    errors++;
                end
                if (out_ch.start_offset !== e.start) begin
                    $error("start_offset expected %0d actual %0d", e.start,
                           out_ch.start_offset);
                    errors++;
                end
                if (out_ch.lexeme_length !== e.len) begin
                    $error("lexeme_length expected %0d actual %0d", e.len,
                           out_ch.lexeme_length);
                    errors++;
                end
                if (out_ch.line_number !== e.line) begin
                    $error("line_number expected %0d actual %0d", e.line,
                           out_ch.line_number);
                    errors++;
                end
                if (out_ch.unterminated !== e.unterm) begin
                    $error("unterminated expected %0d actual %0d", e.unterm,
                           out_ch.unterminated);
                    errors++;
                end
                if (out_ch.last_result !== e.last) begin
                    $error("last_result expected %0d actual %0d", e.last,
                           out_ch.last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_operators();
        send_text("(){},.-+;* ! != = == > >= < <= / a//x\n@#", 0);
        send_word("=", 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_keywords();
        send_text("and class else false for fun if or print return super this ", 0);
        send_text("true var while whilex _A9 classes ", 0);
        send_text("\"s\nt\" 12 3.5 1.x 7.", 1);
    endtask

    task automatic test_edges();
        send_text("\"open", 1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h7F, 1'b0, 1'b0);
        send_text("wor", 1);
        send_word(8'h00, 1'b0, 1'b1);
        send_text("<", 1);
    endtask

    function automatic string random_lexeme();
        string pool[] = '{"and", "class", "x1", "foo_bar", "if", "while", "print",
                          "42", "3.14", "9.", "\"hi\"", "\"a\nb\"", "==", "!=", "<=",
                          ">=", "//c\n", "(", ")", ";", "+", "-", "*", "/", "{", "}",
                          "this", "true", "var", "return", "super", "or", "fun"};
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic test_random(int count);
        int sent;
        string s;
        logic [7:0] b;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) < 7) begin
                s = random_lexeme();
                for (int i = 0; i < s.len(); i++) begin
                    send_word(s[i], 1'b1, 1'b0);
                    sent++;
                end
                b = ($urandom_range(3) == 0) ? 8'h0A : 8'h20;
                if ($urandom_range(2) != 0) begin
                    send_word(b, 1'b1, 1'b0);
                    sent++;
                end
            end else begin
                b = 8'($urandom);
                send_word(b, $urandom_range(4) != 0, $urandom_range(9) == 0);
                sent++;
            end
        end
        send_word(8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_off = 60;
        send_text("((((((((((", 0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    initial begin
        first_line_q = 16'd1;
        restart_scan();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_operators();
        write_first_line(16'hFFFF);
        send_text("a\nb\n", 1);
        write_first_line(16'd0);
        send_idle_pct = 60;
        test_keywords();
        send_idle_pct = 0;
        recv_stall_pct = 60;
        write_first_line(16'd1234);
        test_edges();
        test_random(8);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        test_random(8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_first_line(16'd1);
        test_backpressure();
        wait_drained();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && expected_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
sv/lts_pkg.sv
sv/lts_in_if.sv
sv/lts_out_if.sv
sv/lts_core.sv
sv/lts_out_buf.sv
sv/lox_token_scanner.sv
bench/tb_top.sv
